// ===== rtl/iral_pkg.sv =====
// Shared types, codes and helper functions for the IPv4 route and ARP lookup block.
`timescale 1ns / 1ps
`default_nettype none

package iral_pkg;

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;

    localparam req_t REQ_ROUTE_WR = 2'd0;
    localparam req_t REQ_ARP_WR   = 2'd1;
    localparam req_t REQ_LOOKUP   = 2'd2;

    localparam status_t STAT_FWD      = 2'd0;
    localparam status_t STAT_NO_ROUTE = 2'd1;
    localparam status_t STAT_ZERO_HOP = 2'd2;
    localparam status_t STAT_NO_ARP   = 2'd3;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [7:0]  port;
        logic [5:0]  plen;
    } route_ent_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } arp_ent_t;

    localparam int ROUTE_W = $bits(route_ent_t);
    localparam int ARP_W   = $bits(arp_ent_t);

    function automatic logic [5:0] mask_len(input logic [31:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + 6'(m[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/iral_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module iral_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ipv4_route_and_arp_lookup.sv =====
// Top level of the IPv4 longest-prefix route lookup with ARP next-hop resolution.
//
// Items enter on start while busy is low. A route write or ARP write is stored
// and yields no result; busy stays low. A lookup raises busy, scans the
// first route_count route entries at one memory read per cycle, keeping the longest
// matching prefix (earliest entry on ties), then scans the first arp_count ARP
// entries at one read per cycle until the next hop matches. No route or a zero next
// hop ends the lookup without the ARP scan. Each memory has a single read port.
// The result beat follows in the first cycle with busy low and the next item can be
// accepted at the edge that ends it; a new item is never taken while busy is high.
// The result appears on status, route_hop, out_port and dest_mac for one cycle with
// done high; the receiver cannot stall, so nothing is held back.
// The APB port writes route_count at address 0 and arp_count at address 4.
// Reset clears both counts and the controller; the tables are undefined until
// written and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_route_and_arp_lookup #(
    parameter int ROUTE_DEPTH = 1024,
    parameter int ARP_DEPTH   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire iral_pkg::req_t    req_type,
    input  wire logic [9:0]        entry_index,
    input  wire logic [31:0]       ip_addr,
    input  wire logic [31:0]       net_mask,
    input  wire logic [31:0]       hop_addr,
    input  wire logic [7:0]        port_num,
    input  wire logic [47:0]       mac_addr,
    output logic                   done,
    output iral_pkg::status_t      status,
    output logic      [31:0]       route_hop,
    output logic      [7:0]        out_port,
    output logic      [47:0]       dest_mac,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    import iral_pkg::*;

    localparam int RA  = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int AA  = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
    localparam int RCW = $clog2(ROUTE_DEPTH + 1);
    localparam int ACW = $clog2(ARP_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUTE = 2'd1;
    localparam logic [1:0] S_ARP   = 2'd2;

    logic [10:0]    route_count_reg;
    logic [4:0]     arp_count_reg;
    logic [1:0]     state_reg, state_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic [ACW-1:0] acnt_reg, acnt_next;
    logic           pend_reg, pend_next;
    logic           found_reg, found_next;
    logic           done_reg, done_next;

    logic [31:0]    dst_reg, dst_next;
    logic [5:0]     blen_reg, blen_next;
    logic [31:0]    hop_reg, hop_next;
    logic [7:0]     port_reg, port_next;
    status_t        status_reg, status_next;
    logic [31:0]    route_hop_reg, route_hop_next;
    logic [7:0]     out_port_reg, out_port_next;
    logic [47:0]    dest_mac_reg, dest_mac_next;

    logic           accept;
    logic           cfg_wr;
    logic           route_we;
    logic           arp_we;
    logic [RCW-1:0] rlim;
    logic [ACW-1:0] alim;
    route_ent_t     route_wdata;
    route_ent_t     route_rd;
    arp_ent_t       arp_wdata;
    arp_ent_t       arp_rd;
    logic [ROUTE_W-1:0] route_rdata;
    logic [ARP_W-1:0]   arp_rdata;
    logic           route_hit;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign route_we = accept && (req_type == REQ_ROUTE_WR) && (32'(entry_index) < ROUTE_DEPTH);
    assign arp_we   = accept && (req_type == REQ_ARP_WR) && (32'(entry_index) < ARP_DEPTH);

    assign route_wdata.prefix = ip_addr;
    assign route_wdata.mask   = net_mask;
    assign route_wdata.hop    = hop_addr;
    assign route_wdata.port   = port_num;
    assign route_wdata.plen   = mask_len(net_mask);
    assign arp_wdata.ip       = ip_addr;
    assign arp_wdata.mac      = mac_addr;

    assign rlim = (32'(route_count_reg) > ROUTE_DEPTH) ? RCW'(ROUTE_DEPTH)
                                                       : RCW'(route_count_reg);
    assign alim = (32'(arp_count_reg) > ARP_DEPTH) ? ACW'(ARP_DEPTH) : ACW'(arp_count_reg);

    iral_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (ROUTE_DEPTH),
        .AW    (RA)
    ) u_route_ram (
        .clk   (clk),
        .we    (route_we),
        .waddr (RA'(entry_index)),
        .wdata (route_wdata),
        .raddr (rcnt_reg[RA-1:0]),
        .rdata (route_rdata)
    );

    iral_ram #(
        .WIDTH (ARP_W),
        .DEPTH (ARP_DEPTH),
        .AW    (AA)
    ) u_arp_ram (
        .clk   (clk),
        .we    (arp_we),
        .waddr (AA'(entry_index)),
        .wdata (arp_wdata),
        .raddr (acnt_reg[AA-1:0]),
        .rdata (arp_rdata)
    );

    assign route_rd  = route_rdata;
    assign arp_rd    = arp_rdata;
    assign route_hit = ((dst_reg ^ route_rd.prefix) & route_rd.mask) == 32'd0;

    always_comb
    begin
        state_next     = state_reg;
        rcnt_next      = rcnt_reg;
        acnt_next      = acnt_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        done_next      = 1'b0;
        dst_next       = dst_reg;
        blen_next      = blen_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        status_next    = status_reg;
        route_hop_next = route_hop_reg;
        out_port_next  = out_port_reg;
        dest_mac_next  = dest_mac_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_LOOKUP))
                begin
                    state_next = S_ROUTE;
                    dst_next   = ip_addr;
                    rcnt_next  = '0;
                    found_next = 1'b0;
                    blen_next  = '0;
                    hop_next   = '0;
                    port_next  = '0;
                end
            end
            S_ROUTE:
            begin
                if (pend_reg && route_hit && (!found_reg || (route_rd.plen > blen_reg)))
                begin
                    found_next = 1'b1;
                    blen_next  = route_rd.plen;
                    hop_next   = route_rd.hop;
                    port_next  = route_rd.port;
                end
                if (rcnt_reg < rlim)
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (!found_reg)
                    begin
                        state_next     = S_IDLE;
                        done_next      = 1'b1;
                        status_next    = STAT_NO_ROUTE;
                        route_hop_next = '0;
                        out_port_next  = '0;
                        dest_mac_next  = '0;
                    end
                    else if (hop_reg == 32'd0)
                    begin
                        state_next     = S_IDLE;
                        done_next      = 1'b1;
                        status_next    = STAT_ZERO_HOP;
                        route_hop_next = '0;
                        out_port_next  = port_reg;
                        dest_mac_next  = '0;
                    end
                    else
                    begin
                        state_next = S_ARP;
                        acnt_next  = '0;
                    end
                end
            end
            S_ARP:
            begin
                if (pend_reg && (arp_rd.ip == hop_reg))
                begin
                    state_next     = S_IDLE;
                    done_next      = 1'b1;
                    status_next    = STAT_FWD;
                    route_hop_next = hop_reg;
                    out_port_next  = port_reg;
                    dest_mac_next  = arp_rd.mac;
                end
                else if (acnt_reg < alim)
                begin
                    acnt_next = acnt_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next     = S_IDLE;
                    done_next      = 1'b1;
                    status_next    = STAT_NO_ARP;
                    route_hop_next = hop_reg;
                    out_port_next  = port_reg;
                    dest_mac_next  = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count_reg <= '0;
            arp_count_reg   <= '0;
            state_reg       <= S_IDLE;
            rcnt_reg        <= '0;
            acnt_reg        <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr && !paddr[2])
            begin
                route_count_reg <= pwdata[10:0];
            end
            if (cfg_wr && paddr[2])
            begin
                arp_count_reg <= pwdata[4:0];
            end
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            acnt_reg  <= acnt_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg       <= dst_next;
        blen_reg      <= blen_next;
        hop_reg       <= hop_next;
        port_reg      <= port_next;
        status_reg    <= status_next;
        route_hop_reg <= route_hop_next;
        out_port_reg  <= out_port_next;
        dest_mac_reg  <= dest_mac_next;
    end

    always_comb
    begin
        if (paddr[2])
        begin
            prdata = {27'd0, arp_count_reg};
        end
        else
        begin
            prdata = {21'd0, route_count_reg};
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign route_hop = route_hop_reg;
    assign out_port  = out_port_reg;
    assign dest_mac  = dest_mac_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("Result beat without a lookup in progress.");

    a_mac_only_forward: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_FWD) |-> (dest_mac == 48'd0))
        else $error("Nonzero MAC on a result that does not forward.");

    a_no_route_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == STAT_NO_ROUTE) |-> (route_hop == 32'd0) && (out_port == 8'd0))
        else $error("No-route result carries route data.");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("Memory read pending while idle.");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (route_we || arp_we) |-> (state_reg == S_IDLE))
        else $error("Table written during a lookup.");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the IPv4 route lookup block with ARP next-hop resolution.
`timescale 1ns / 1ps

module tb_top;

    import iral_pkg::*;

    localparam int ROUTE_SLOTS = 1024;
    localparam int ARP_SLOTS = 16;
    localparam req_t REQ_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_ROUTE_COUNT = 3'd0;
    localparam logic [2:0] ADDR_ARP_COUNT = 3'd4;
    localparam logic RD = 1'b0;
    localparam logic WR = 1'b1;
    localparam int STALL_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ROUNDS = 7;
    localparam int ROUND_ITEMS = 50;
    localparam int DENSE_ROUTES = 64;

    typedef struct packed {
        status_t     status;
        logic [31:0] route_hop;
        logic [7:0]  out_port;
        logic [47:0] dest_mac;
    } lookup_res_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req_type;
    logic [9:0]  entry_index;
    logic [31:0] ip_addr;
    logic [31:0] net_mask;
    logic [31:0] hop_addr;
    logic [7:0]  port_num;
    logic [47:0] mac_addr;
    logic        done;
    status_t     status;
    logic [31:0] route_hop;
    logic [7:0]  out_port;
    logic [47:0] dest_mac;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [31:0] rt_prefix [ROUTE_SLOTS];
    logic [31:0] rt_mask [ROUTE_SLOTS];
    logic [31:0] rt_hop [ROUTE_SLOTS];
    logic [7:0]  rt_port [ROUTE_SLOTS];
    bit          rt_written [ROUTE_SLOTS];
    logic [31:0] arp_ip [ARP_SLOTS];
    logic [47:0] arp_mac [ARP_SLOTS];
    logic [10:0] route_count_reg = '0;
    logic [4:0]  arp_count_reg = '0;
    int          route_fill = 0;

    lookup_res_t lookup_results_q [$];
    int          mismatches = 0;
    int          lookups_sent = 0;
    int          table_writes = 0;
    int          settings_applied = 0;
    int          beats_checked = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;

    ipv4_route_and_arp_lookup dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic lookup_res_t predict_route_lookup(logic [31:0] dst);
        int          lim;
        int          best;
        int          best_len;
        bit          found;
        lookup_res_t r;
        lim = (route_count_reg > ROUTE_SLOTS) ? ROUTE_SLOTS : int'(route_count_reg);
        found = 0;
        best = 0;
        best_len = 0;
        for (int i = 0; i < lim; i++)
        begin
            if (((dst & rt_mask[i]) == (rt_prefix[i] & rt_mask[i]))
                && (!found || $countones(rt_mask[i]) > best_len))
            begin
                found = 1;
                best = i;
                best_len = $countones(rt_mask[i]);
            end
        end
        r = '0;
        if (!found)
        begin
            r.status = STAT_NO_ROUTE;
            return r;
        end
        r.out_port = rt_port[best];
        if (rt_hop[best] == 32'h0)
        begin
            r.status = STAT_ZERO_HOP;
            return r;
        end
        r.route_hop = rt_hop[best];
        r.status = STAT_NO_ARP;
        lim = (arp_count_reg > ARP_SLOTS) ? ARP_SLOTS : int'(arp_count_reg);
        // Walking down means the lowest matching slot is the one that sticks.
        for (int i = lim - 1; i >= 0; i--)
        begin
            if (arp_ip[i] == rt_hop[best])
            begin
                r.status = STAT_FWD;
                r.dest_mac = arp_mac[i];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic logic [31:0] random_mask();
        if ($urandom_range(0, 99) < 85)
            return prefix_mask($urandom_range(0, 32));
        return $urandom;
    endfunction

    function automatic logic [31:0] random_hop();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return arp_ip[$urandom_range(0, ARP_SLOTS - 1)];
        if (roll < 80)
            return 32'h0;
        return $urandom;
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(req_t kind, logic [9:0] idx, logic [31:0] ip,
                                logic [31:0] mask, logic [31:0] hop, logic [7:0] port,
                                logic [47:0] mac);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        req_type <= kind;
        entry_index <= idx;
        ip_addr <= ip;
        net_mask <= mask;
        hop_addr <= hop;
        port_num <= port;
        mac_addr <= mac;
        do
            @(posedge clk);
        while (busy);
        case (kind)
            REQ_ROUTE_WR:
            begin
                rt_prefix[idx] = ip;
                rt_mask[idx] = mask;
                rt_hop[idx] = hop;
                rt_port[idx] = port;
                rt_written[idx] = 1;
                while (route_fill < ROUTE_SLOTS && rt_written[route_fill])
                    route_fill++;
                table_writes++;
            end
            REQ_ARP_WR:
            begin
                if (idx < ARP_SLOTS)
                begin
                    arp_ip[idx] = ip;
                    arp_mac[idx] = mac;
                end
                table_writes++;
            end
            REQ_LOOKUP:
            begin
                lookup_results_q.push_back(predict_route_lookup(ip));
                lookups_sent++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic write_route(logic [9:0] idx, logic [31:0] prefix, logic [31:0] mask,
                               logic [31:0] hop, logic [7:0] port);
        send_request(REQ_ROUTE_WR, idx, prefix, mask, hop, port, rand_mac());
    endtask

    task automatic write_arp(logic [9:0] idx, logic [31:0] ip, logic [47:0] mac);
        send_request(REQ_ARP_WR, idx, ip, $urandom, $urandom, 8'($urandom), mac);
    endtask

    task automatic lookup_dest(logic [31:0] dst);
        send_request(REQ_LOOKUP, 10'($urandom), dst, $urandom, $urandom, 8'($urandom),
                     rand_mac());
    endtask

    task automatic go_quiet();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic reg_access(logic wr, logic [2:0] addr, logic [31:0] data);
        logic [31:0] want;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr)
        begin
            case (addr)
                ADDR_ROUTE_COUNT: route_count_reg = data[10:0];
                ADDR_ARP_COUNT:   arp_count_reg = data[4:0];
                default:
                begin
                end
            endcase
            settings_applied++;
        end
        else
        begin
            want = (addr == ADDR_ROUTE_COUNT) ? 32'(route_count_reg) : 32'(arp_count_reg);
            if (prdata !== want)
                report_mismatch("register read", 64'(prdata), 64'(want));
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Counts change only with the block idle and every lookup answered.
    task automatic set_counts(int routes, int arps);
        go_quiet();
        while (lookup_results_q.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        reg_access(WR, ADDR_ROUTE_COUNT, 32'(routes));
        reg_access(RD, ADDR_ROUTE_COUNT, 32'h0);
        reg_access(WR, ADDR_ARP_COUNT, 32'(arps));
        reg_access(RD, ADDR_ARP_COUNT, 32'h0);
    endtask

    task automatic test_reset_values();
        reg_access(RD, ADDR_ROUTE_COUNT, 32'h0);
        reg_access(RD, ADDR_ARP_COUNT, 32'h0);
        lookup_dest($urandom);
        send_request(REQ_UNUSED, 10'h3FF, $urandom, $urandom, $urandom, 8'($urandom),
                     rand_mac());
    endtask

    task automatic test_lookup_outcomes();
        write_arp(0, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF);
        write_arp(1, 32'h0A00_0002, 48'h0);
        write_arp(2, 32'h0A00_0001, 48'h0000_1111_2222);
        write_arp(3, 32'hFFFF_FFFF, 48'h0123_4567_89AB);
        write_arp(ARP_SLOTS, 32'h0A00_0009, 48'hAAAA_BBBB_CCCC);
        write_arp(10'h3FF, 32'h0A00_0009, 48'hDDDD_EEEE_FFFF);
        write_route(0, 32'hFFFF_FFFF, 32'h0, 32'h0A00_0002, 8'hFF);
        write_route(1, 32'h0A01_0000, prefix_mask(16), 32'h0A00_0001, 8'h01);
        write_route(2, 32'h0A01_0000, prefix_mask(16), 32'h0A00_0002, 8'h02);
        write_route(3, 32'h0A01_0200, prefix_mask(24), 32'h0, 8'h03);
        write_route(4, 32'h0A01_0300, prefix_mask(24), 32'h0A00_0009, 8'h04);
        write_route(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        write_route(6, 32'h0A0A_0A0A, 32'h0F0F_0F0F, 32'h0A00_0001, 8'h06);
        set_counts(7, 4);
        lookup_dest(32'h0A01_0505);
        lookup_dest(32'h0A01_0207);
        lookup_dest(32'h0A01_0301);
        lookup_dest(32'hFFFF_FFFF);
        lookup_dest(32'hC0A8_0001);
        lookup_dest(32'h0A0A_0A0A);
        set_counts(7, 0);
        lookup_dest(32'h0A01_0505);
    endtask

    task automatic test_arp_limits();
        for (int i = 4; i < ARP_SLOTS - 1; i++)
            write_arp(10'(i), $urandom, rand_mac());
        write_arp(ARP_SLOTS - 1, 32'hC0A8_0101, rand_mac());
        write_route(7, 32'hC0A8_0100, prefix_mask(24), 32'hC0A8_0101, 8'h07);
        set_counts(8, ARP_SLOTS);
        lookup_dest(32'hC0A8_0155);
        set_counts(8, 31);
        lookup_dest(32'hC0A8_0155);
        set_counts(8, ARP_SLOTS - 1);
        lookup_dest(32'hC0A8_0155);
    endtask

    task automatic test_random_traffic();
        int          roll;
        int          hi;
        int          r;
        int          routes;
        logic [31:0] dst;
        logic [31:0] ip;
        for (int round = 0; round < RANDOM_ROUNDS; round++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                routes = 0;
            else if (roll < 25)
                routes = route_fill;
            else
                routes = $urandom_range(1, route_fill);
            set_counts(routes, ($urandom_range(0, 99) < 15) ? $urandom_range(ARP_SLOTS + 1, 31)
                                                            : $urandom_range(0, ARP_SLOTS));
            no_idle = (round % 4 == 3);
            for (int k = 0; k < ROUND_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    if (route_fill > 0 && $urandom_range(0, 99) < 65)
                    begin
                        r = $urandom_range(0, route_fill - 1);
                        dst = (rt_prefix[r] & rt_mask[r]) | ($urandom & ~rt_mask[r]);
                    end
                    else
                        dst = $urandom;
                    lookup_dest(dst);
                end
                else if (roll < 72)
                begin
                    hi = (route_fill < 63) ? route_fill : 63;
                    write_route(10'(($urandom_range(0, 99) < 65)
                                    ? $urandom_range(0, hi)
                                    : $urandom_range(0, ROUTE_SLOTS - 1)),
                                $urandom, random_mask(), random_hop(), 8'($urandom));
                end
                else if (roll < 92)
                begin
                    if (route_fill > 0 && $urandom_range(0, 99) < 50)
                        ip = rt_hop[$urandom_range(0, route_fill - 1)];
                    else
                        ip = $urandom;
                    write_arp(10'(($urandom_range(0, 99) < 85)
                                  ? $urandom_range(0, ARP_SLOTS - 1)
                                  : $urandom_range(ARP_SLOTS, 1023)),
                              ip, rand_mac());
                end
                else
                    send_request(REQ_UNUSED, 10'($urandom), $urandom, $urandom, $urandom,
                                 8'($urandom), rand_mac());
            end
            no_idle = 0;
        end
    endtask

    task automatic test_wide_route_scan();
        int r;
        no_idle = 1;
        for (int i = 0; i < DENSE_ROUTES - 1; i++)
        begin
            if (!rt_written[i])
                write_route(10'(i), $urandom, random_mask(), random_hop(), 8'($urandom));
        end
        write_route(DENSE_ROUTES - 1, 32'hDEAD_BEEF, 32'hFFFF_FFFF, arp_ip[5], 8'hA5);
        no_idle = 0;
        set_counts(route_fill, ARP_SLOTS);
        lookup_dest(32'hDEAD_BEEF);
        r = $urandom_range(0, route_fill - 1);
        lookup_dest((rt_prefix[r] & rt_mask[r]) | ($urandom & ~rt_mask[r]));
        lookup_dest($urandom);
        set_counts(route_fill, 31);
        lookup_dest(32'hDEAD_BEEF);
        r = $urandom_range(0, route_fill - 1);
        lookup_dest((rt_prefix[r] & rt_mask[r]) | ($urandom & ~rt_mask[r]));
        lookup_dest($urandom);
    endtask

    always @(posedge clk)
    begin : check_result_beat
        lookup_res_t want;
        if (rst_n && done)
        begin
            beats_checked++;
            if (lookup_results_q.size() == 0)
                report_mismatch("result beat with no lookup pending", 64'(route_hop), 64'h0);
            else
            begin
                want = lookup_results_q.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (route_hop !== want.route_hop)
                    report_mismatch("route_hop", 64'(route_hop), 64'(want.route_hop));
                if (out_port !== want.out_port)
                    report_mismatch("out_port", 64'(out_port), 64'(want.out_port));
                if (dest_mac !== want.dest_mac)
                    report_mismatch("dest_mac", 64'(dest_mac), 64'(want.dest_mac));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ROUTE_WR;
        entry_index = '0;
        ip_addr = '0;
        net_mask = '0;
        hop_addr = '0;
        port_num = '0;
        mac_addr = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_lookup_outcomes();
        test_arp_limits();
        test_random_traffic();
        test_wide_route_scan();
        go_quiet();
        while (lookup_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d lookups and %0d table writes under %0d count settings.",
                 lookups_sent, table_writes, settings_applied);
        $display("Checked %0d result beats, with %0d mismatches.", beats_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/iral_pkg.sv
rtl/iral_ram.sv
rtl/ipv4_route_and_arp_lookup.sv
tb/tb_top.sv
